// File: rtl/shmf_pkg.sv
// Shared types and constants of the sliding histogram median filter.
package shmf_pkg;

    localparam int BINS           = 256;
    localparam int BIN_W          = 8;
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_KERNEL = 15;
    localparam int MAX_HEIGHT     = 2048;
    localparam int KSIZE_W        = 4;
    localparam int DIM_W          = 12;
    localparam int COORD_W        = 11;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [KSIZE_W-1:0] RESET_KERNEL = 4'd3;
    localparam logic [DIM_W-1:0]   RESET_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0]   RESET_HEIGHT = 12'd480;

    typedef struct packed {
        logic [BIN_W-1:0] pixel;
        logic             frame_start;
    } pixel_item_t;

    typedef struct packed {
        logic [BIN_W-1:0]   median_value;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic               frame_end;
    } median_item_t;

endpackage

// File: rtl/sliding_histogram_median_filter.sv
// Sliding-window median filter over a raster stream of 8-bit grey pixels.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   in      | in        | in_valid/in_stall  | pixel_item_t  (pixel, frame_start)
//   out     | out       | out_valid/out_stall| median_item_t (median, centre, end)
//   cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A pixel without a median takes one line-store read per stacked row plus a row
// copy through the single read port of the window memory. A pixel with a median
// then fills the histogram from the k*k window, sweeps the 256 bins, clearing
// them as it goes, and loads the output register.
// After reset a clearing pass over max(256, window slots) addresses (256 by default)
// runs before the first pixel is taken; configuration writes are taken throughout.
// A finished median waits in the output register while the next pixel is worked on;
// a second median holds the input stalled until the first has been taken.
module sliding_histogram_median_filter
    import shmf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = DEF_MAX_KERNEL
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pixel_item_t          in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output median_item_t         out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    localparam int SD     = MAX_KERNEL - 1;
    localparam int TOP_K  = ((MAX_KERNEL % 2) == 0) ? MAX_KERNEL - 1 : MAX_KERNEL;
    localparam int PW     = $clog2(MAX_WIDTH + 1);
    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int RW     = 12;
    localparam int LSD    = MAX_WIDTH * SD;
    localparam int LAW    = $clog2(LSD);
    localparam int KW     = $clog2(MAX_KERNEL);
    localparam int WAW    = 2 * KW;
    localparam int WD     = 1 << WAW;
    localparam int CLR_N  = (WD > BINS) ? WD : BINS;
    localparam int CTW    = $clog2(CLR_N + 1);

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_COPY  = 3'd3;
    localparam logic [2:0] ST_BUILD = 3'd4;
    localparam logic [2:0] ST_SCAN  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // memories
    logic [BIN_W-1:0] ls_mem   [LSD];
    logic [BIN_W-1:0] win_mem  [WD];
    logic [BIN_W-1:0] hist_mem [BINS];

    logic             ls_we;
    logic [LAW-1:0]   ls_waddr, ls_raddr;
    logic [BIN_W-1:0] ls_wdata, ls_q_reg;
    logic             win_we;
    logic [WAW-1:0]   win_waddr, win_raddr;
    logic [BIN_W-1:0] win_wdata, win_q_reg;
    logic             hist_we;
    logic [BIN_W-1:0] hist_waddr, hist_raddr;
    logic [BIN_W-1:0] hist_wdata, hist_q_reg;

    // registers
    logic [2:0]         state_reg, state_next;
    logic [CTW-1:0]     cnt_reg, cnt_next;
    logic [KSIZE_W-1:0] kernel_reg, kernel_next;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic [PW-1:0]      col_reg, col_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [KW-1:0]      map_reg  [MAX_KERNEL];
    logic [KW-1:0]      map_next [MAX_KERNEL];
    logic [KW-1:0]      bmap_reg [MAX_KERNEL];
    logic [KW-1:0]      bmap_next[MAX_KERNEL];
    logic [KW-1:0]      p_reg, p_next, q_reg, q_next;
    logic [KW-1:0]      c_reg, c_next, r_reg, r_next;
    logic [KSIZE_W-1:0] k_reg, k_next;
    logic [BIN_W-1:0]   kk_reg, kk_next;
    logic [XW-1:0]      x_reg, x_next;
    logic [BIN_W-1:0]   px_reg, px_next;
    logic [COORD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic               fe_reg, fe_next;
    logic               emit_reg, emit_next;
    logic               issue_done_reg, issue_done_next;
    logic               b1_reg, b1_next, b2_reg, b2_next;
    logic [BIN_W-1:0]   v2_reg, v2_next;
    logic               lw_valid_reg, lw_valid_next;
    logic [BIN_W-1:0]   lw_addr_reg, lw_addr_next, lw_val_reg, lw_val_next;
    logic [BIN_W-1:0]   cum_reg, cum_next;
    logic               found_reg, found_next;
    logic [BIN_W-1:0]   med_reg, med_next;
    logic               out_valid_reg, out_valid_next;
    median_item_t       out_data_reg, out_data_next;

    // effective settings and position of the incoming pixel
    logic [KSIZE_W-1:0] kodd, k_eff;
    logic [PW-1:0]      eff_w;
    logic [RW-1:0]      eff_h;
    logic [PW-1:0]      acc_col, nxt_col;
    logic [RW-1:0]      acc_row, nxt_row;
    logic               acc_emit, acc_fe;
    logic [KW-1:0]      q_sel;
    logic               in_accept;
    logic [BIN_W-1:0]   cum_sum, fwd_cnt;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        kodd = kernel_reg | KSIZE_W'(1);
        if (32'(kodd) > TOP_K)
            k_eff = KSIZE_W'(TOP_K);
        else
            k_eff = kodd;

        if (width_reg == '0)
            eff_w = PW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            eff_w = PW'(MAX_WIDTH);
        else
            eff_w = PW'(width_reg);

        if (height_reg == '0)
            eff_h = RW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            eff_h = RW'(MAX_HEIGHT);
        else
            eff_h = RW'(height_reg);
    end

    always_comb
    begin
        acc_col = in_data.frame_start ? '0 : col_reg;
        acc_row = in_data.frame_start ? '0 : row_reg;
        if (acc_col >= eff_w)
        begin
            acc_col = '0;
            acc_row = acc_row + 1'b1;
        end
        if (acc_row >= eff_h)
            acc_row = '0;

        acc_emit = (32'(acc_col) + 1 >= 32'(k_eff)) && (32'(acc_row) + 1 >= 32'(k_eff));
        acc_fe   = (32'(acc_col) + 1 == 32'(eff_w)) && (32'(acc_row) + 1 == 32'(eff_h));

        nxt_col = acc_col + 1'b1;
        nxt_row = acc_row;
        if (nxt_col >= eff_w)
        begin
            nxt_col = '0;
            nxt_row = acc_row + 1'b1;
            if (nxt_row >= eff_h)
                nxt_row = '0;
        end
    end

    // slot that holds the rightmost column before the shift
    always_comb
    begin
        q_sel = '0;
        for (int c = 0; c < MAX_KERNEL; c++)
        begin
            if (c == 32'(k_eff) - 1)
                q_sel = map_reg[c];
        end
    end

    assign cum_sum = cum_reg + hist_q_reg;
    assign fwd_cnt = (lw_valid_reg && (lw_addr_reg == v2_reg)) ? lw_val_reg : hist_q_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        kernel_next     = kernel_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        map_next        = map_reg;
        bmap_next       = bmap_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        c_next          = c_reg;
        r_next          = r_reg;
        k_next          = k_reg;
        kk_next         = kk_reg;
        x_next          = x_reg;
        px_next         = px_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        fe_next         = fe_reg;
        emit_next       = emit_reg;
        issue_done_next = issue_done_reg;
        b1_next         = 1'b0;
        b2_next         = 1'b0;
        v2_next         = v2_reg;
        lw_valid_next   = 1'b0;
        lw_addr_next    = lw_addr_reg;
        lw_val_next     = lw_val_reg;
        cum_next        = cum_reg;
        found_next      = found_reg;
        med_next        = med_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        ls_we      = 1'b0;
        ls_waddr   = '0;
        ls_wdata   = '0;
        ls_raddr   = '0;
        win_we     = 1'b0;
        win_waddr  = '0;
        win_wdata  = '0;
        win_raddr  = '0;
        hist_we    = 1'b0;
        hist_waddr = '0;
        hist_wdata = '0;
        hist_raddr = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLR:
            begin
                hist_we    = 1'b1;
                hist_waddr = BIN_W'(cnt_reg);
                win_we     = 1'b1;
                win_waddr  = WAW'(cnt_reg);
                if (32'(cnt_reg) == CLR_N - 1)
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end

            ST_IDLE:
            begin
                if (in_accept)
                begin
                    col_next  = nxt_col;
                    row_next  = nxt_row;
                    x_next    = XW'(acc_col);
                    px_next   = in_data.pixel;
                    k_next    = k_eff;
                    kk_next   = BIN_W'({4'd0, k_eff} * {4'd0, k_eff});
                    cx_next   = COORD_W'(32'(acc_col) - 32'(k_eff >> 1));
                    cy_next   = COORD_W'(32'(acc_row) - 32'(k_eff >> 1));
                    fe_next   = acc_fe;
                    emit_next = acc_emit;
                    p_next    = map_reg[0];
                    q_next    = q_sel;
                    // shift the window left; the dropped slot takes the new column
                    for (int c = 0; c < MAX_KERNEL - 1; c++)
                    begin
                        if (c + 1 < 32'(k_eff))
                            map_next[c] = map_reg[c + 1];
                    end
                    for (int c = 0; c < MAX_KERNEL; c++)
                    begin
                        if (c == 32'(k_eff) - 1)
                            map_next[c] = map_reg[0];
                    end
                    cnt_next   = '0;
                    state_next = ST_LOAD;
                end
            end

            ST_LOAD:
            begin
                if (32'(cnt_reg) + 1 < 32'(k_reg))
                    ls_raddr = LAW'(32'(x_reg) * SD + 32'(cnt_reg));
                if (cnt_reg != '0 && 32'(cnt_reg) < 32'(k_reg))
                begin
                    win_we    = 1'b1;
                    win_waddr = {p_reg, KW'(cnt_reg - 1'b1)};
                    win_wdata = ls_q_reg;
                    if (32'(cnt_reg) >= 2)
                    begin
                        ls_we    = 1'b1;
                        ls_waddr = LAW'(32'(x_reg) * SD + 32'(cnt_reg) - 2);
                        ls_wdata = ls_q_reg;
                    end
                end
                if (32'(cnt_reg) == 32'(k_reg))
                begin
                    win_we    = 1'b1;
                    win_waddr = {p_reg, KW'(k_reg - 1'b1)};
                    win_wdata = px_reg;
                    if (k_reg > KSIZE_W'(1))
                    begin
                        ls_we    = 1'b1;
                        ls_waddr = LAW'(32'(x_reg) * SD + 32'(k_reg) - 2);
                        ls_wdata = px_reg;
                    end
                    cnt_next   = CTW'(k_reg);
                    state_next = ST_COPY;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end

            ST_COPY:
            begin
                // rows below the window follow the column that held the right edge
                if (32'(cnt_reg) < MAX_KERNEL)
                    win_raddr = {q_reg, KW'(cnt_reg)};
                if (32'(cnt_reg) > 32'(k_reg) && p_reg != q_reg)
                begin
                    win_we    = 1'b1;
                    win_waddr = {p_reg, KW'(cnt_reg - 1'b1)};
                    win_wdata = win_q_reg;
                end
                if (32'(cnt_reg) == MAX_KERNEL)
                begin
                    bmap_next       = map_reg;
                    c_next          = '0;
                    r_next          = '0;
                    issue_done_next = 1'b0;
                    cnt_next        = '0;
                    state_next      = emit_reg ? ST_BUILD : ST_IDLE;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end

            ST_BUILD:
            begin
                if (!issue_done_reg)
                begin
                    win_raddr = {bmap_reg[0], r_reg};
                    b1_next   = 1'b1;
                    if (32'(r_reg) + 1 == 32'(k_reg))
                    begin
                        r_next = '0;
                        if (32'(c_reg) + 1 == 32'(k_reg))
                            issue_done_next = 1'b1;
                        else
                        begin
                            c_next = c_reg + 1'b1;
                            for (int c = 0; c < MAX_KERNEL - 1; c++)
                                bmap_next[c] = bmap_reg[c + 1];
                        end
                    end
                    else
                        r_next = r_reg + 1'b1;
                end
                if (b1_reg)
                begin
                    hist_raddr = win_q_reg;
                    b2_next    = 1'b1;
                    v2_next    = win_q_reg;
                end
                if (b2_reg)
                begin
                    // the bin read may miss the write of the previous cycle
                    hist_we       = 1'b1;
                    hist_waddr    = v2_reg;
                    hist_wdata    = fwd_cnt + 1'b1;
                    lw_valid_next = 1'b1;
                    lw_addr_next  = v2_reg;
                    lw_val_next   = fwd_cnt + 1'b1;
                end
                if (issue_done_reg && !b1_reg && !b2_reg)
                begin
                    cnt_next   = '0;
                    cum_next   = '0;
                    found_next = 1'b0;
                    med_next   = BIN_W'(BINS - 1);
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // read and clear each bin in the same cycle
                if (32'(cnt_reg) < BINS)
                begin
                    hist_raddr = BIN_W'(cnt_reg);
                    hist_we    = 1'b1;
                    hist_waddr = BIN_W'(cnt_reg);
                end
                if (cnt_reg != '0)
                begin
                    cum_next = cum_sum;
                    if (!found_reg && (cum_sum > (kk_reg >> 1)))
                    begin
                        found_next = 1'b1;
                        med_next   = BIN_W'(cnt_reg - 1'b1);
                    end
                end
                if (32'(cnt_reg) == BINS)
                    state_next = ST_DONE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.median_value  = med_reg;
                    out_data_next.center_x      = cx_reg;
                    out_data_next.center_y      = cy_reg;
                    out_data_next.frame_end     = fe_reg;
                    state_next                  = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KERNEL_SIZE:  kernel_next = cfg_data[KSIZE_W-1:0];
                REG_IMAGE_WIDTH:  width_next  = cfg_data;
                REG_IMAGE_HEIGHT: height_next = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            cnt_reg        <= '0;
            kernel_reg     <= RESET_KERNEL;
            width_reg      <= RESET_WIDTH;
            height_reg     <= RESET_HEIGHT;
            col_reg        <= '0;
            row_reg        <= '0;
            for (int i = 0; i < MAX_KERNEL; i++)
            begin
                map_reg[i]  <= KW'(i);
                bmap_reg[i] <= KW'(i);
            end
            issue_done_reg <= 1'b0;
            b1_reg         <= 1'b0;
            b2_reg         <= 1'b0;
            lw_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            emit_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            kernel_reg     <= kernel_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            map_reg        <= map_next;
            bmap_reg       <= bmap_next;
            issue_done_reg <= issue_done_next;
            b1_reg         <= b1_next;
            b2_reg         <= b2_next;
            lw_valid_reg   <= lw_valid_next;
            found_reg      <= found_next;
            emit_reg       <= emit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        q_reg        <= q_next;
        c_reg        <= c_next;
        r_reg        <= r_next;
        k_reg        <= k_next;
        kk_reg       <= kk_next;
        x_reg        <= x_next;
        px_reg       <= px_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        fe_reg       <= fe_next;
        v2_reg       <= v2_next;
        lw_addr_reg  <= lw_addr_next;
        lw_val_reg   <= lw_val_next;
        cum_reg      <= cum_next;
        med_reg      <= med_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (ls_we)
            ls_mem[ls_waddr] <= ls_wdata;
        ls_q_reg <= ls_mem[ls_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (win_we)
            win_mem[win_waddr] <= win_wdata;
        win_q_reg <= win_mem[win_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_waddr] <= hist_wdata;
        hist_q_reg <= hist_mem[hist_raddr];
    end

`ifndef SYNTHESIS
    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cum_reg <= kk_reg))
        else $error("cumulative count exceeds window size");

    a_done_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> found_reg)
        else $error("bin sweep ended without a median");

    a_build_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (!b1_reg && !b2_reg))
        else $error("histogram update still in flight during sweep");
`endif

endmodule

// File: test/testbench.sv
// Self-checking testbench for the sliding histogram median filter.
module testbench;
    import shmf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK     = DEF_MAX_KERNEL - 1;
    localparam int SETTLE    = 64;
    localparam int LIMIT     = 8000000;

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_stall;
    pixel_item_t  in_data;
    logic         out_valid;
    logic         out_stall;
    median_item_t out_data;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    // shadow of the block's state
    logic [7:0]   line_rows [0:DEF_MAX_WIDTH*STACK-1];
    logic [7:0]   window_px [0:DEF_MAX_KERNEL-1][0:DEF_MAX_KERNEL-1];
    int unsigned  col_pos;
    int unsigned  row_pos;
    logic [KSIZE_W-1:0] kernel_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;

    median_item_t expected_medians[$];
    int           error_count;
    int           cycle_count;
    int           sender_idle_pct;
    int           stall_pct;
    int           hold_left;

    sliding_histogram_median_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // long hold-off counts down here; the stall driver only reads it
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < stall_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        median_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_medians.size() == 0)
            begin
                report_mismatch("unexpected median", out_data.median_value, 0);
            end
            else
            begin
                want = expected_medians.pop_front();
                if (out_data.median_value !== want.median_value)
                    report_mismatch("median_value", out_data.median_value,
                                    want.median_value);
                if (out_data.center_x !== want.center_x)
                    report_mismatch("center_x", out_data.center_x, want.center_x);
                if (out_data.center_y !== want.center_y)
                    report_mismatch("center_y", out_data.center_y, want.center_y);
                if (out_data.frame_end !== want.frame_end)
                    report_mismatch("frame_end", out_data.frame_end, want.frame_end);
            end
        end
    end

    function automatic int unsigned active_kernel();
        int unsigned k;
        k = kernel_reg | 4'd1;
        if (k > DEF_MAX_KERNEL)
            k = DEF_MAX_KERNEL;
        return k;
    endfunction

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned top);
        if (v == 0)
            return 1;
        if (v > top)
            return top;
        return v;
    endfunction

    // advance the shadow state by one pixel and queue the median it yields
    function automatic void predict_median(input pixel_item_t item);
        int unsigned  k, w, h, x, y, base, half, cum, r;
        int unsigned  counts [0:BINS-1];
        median_item_t res;
        k = active_kernel();
        w = clamp_dim(width_reg, DEF_MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        if (item.frame_start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        x = col_pos;
        y = row_pos;
        for (int c = 0; c + 1 < k; c++)
            for (int j = 0; j < DEF_MAX_KERNEL; j++)
                window_px[c][j] = window_px[c+1][j];
        base = x * STACK;
        for (int j = 0; j + 1 < k; j++)
            window_px[k-1][j] = line_rows[base+j];
        window_px[k-1][k-1] = item.pixel;
        if (k > 1)
        begin
            for (int j = 0; j + 2 < k; j++)
                line_rows[base+j] = line_rows[base+j+1];
            line_rows[base+k-2] = item.pixel;
        end
        if (x + 1 >= k && y + 1 >= k)
        begin
            foreach (counts[v])
                counts[v] = 0;
            for (int c = 0; c < k; c++)
                for (int j = 0; j < k; j++)
                    counts[window_px[c][j]]++;
            half = (k * k) / 2;
            cum = 0;
            res.median_value = 8'd255;
            for (int v = 0; v < BINS; v++)
            begin
                cum += counts[v];
                if (cum > half)
                begin
                    res.median_value = 8'(v);
                    break;
                end
            end
            r = k / 2;
            res.center_x = COORD_W'(x - r);
            res.center_y = COORD_W'(y - r);
            res.frame_end = (x + 1 == w && y + 1 == h);
            expected_medians.push_back(res);
        end
        col_pos = x + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = y + 1;
            if (row_pos >= h)
                row_pos = 0;
        end
    endfunction

    // valid stays high between back-to-back transfers; it is lowered only for a gap
    task automatic send_pixel(input logic [7:0] px, input logic fs);
        pixel_item_t item;
        item.pixel = px;
        item.frame_start = fs;
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_median(item);
    endtask

    // valid is left high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_KERNEL_SIZE:  kernel_reg = value[KSIZE_W-1:0];
            REG_IMAGE_WIDTH:  width_reg = value;
            REG_IMAGE_HEIGHT: height_reg = value;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_medians.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_geometry(input int k, input int w, input int h);
        wait_drained();
        write_reg(REG_KERNEL_SIZE, DIM_W'(k));
        write_reg(REG_IMAGE_WIDTH, DIM_W'(w));
        write_reg(REG_IMAGE_HEIGHT, DIM_W'(h));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_pixel();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(120, 135));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one frame; noise drops a stray frame start in now and then
    task automatic send_frame(input int w, input int h, input int noise_pct);
        for (int i = 0; i < w * h; i++)
            send_pixel(random_pixel(), (i == 0) || ($urandom_range(0, 99) < noise_pct));
    endtask

    task automatic test_reset_defaults();
        // 640 wide: a few pixels of row 0 give no median
        for (int i = 0; i < 6; i++)
            send_pixel(random_pixel(), i == 0);
    endtask

    task automatic test_directed_windows();
        set_geometry(3, 3, 3);
        for (int i = 0; i < 9; i++)
            send_pixel(8'd0, i == 0);
        for (int i = 0; i < 9; i++)
            send_pixel(8'd255, i == 0);
        // even kernel forced odd, descending ramp
        set_geometry(2, 3, 3);
        for (int i = 0; i < 9; i++)
            send_pixel(8'd250 - 8'(i * 20), i == 0);
    endtask

    task automatic test_register_extremes();
        // kernel 0 acts as 1, zero height as one row, oversized width
        set_geometry(0, 4095, 0);
        for (int i = 0; i < 40; i++)
            send_pixel(random_pixel(), i == 0);
        // kernel above the image: nothing comes out
        set_geometry(15, 4, 4);
        send_frame(4, 4, 0);
        // largest kernel on the smallest image that fits it
        set_geometry(15, 15, 15);
        send_frame(15, 15, 0);
        set_geometry(14, 16, 4095);
        send_frame(16, 15, 0);
        // implicit wrap into the next frame without a frame start
        set_geometry(3, 4, 3);
        for (int i = 0; i < 24; i++)
            send_pixel(random_pixel(), i == 0);
    endtask

    task automatic test_random_frames(input int idle, input int stall, input int pixels);
        int sent, k, w, h;
        sender_idle_pct = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < pixels)
        begin
            k = 2 * $urandom_range(0, 2) + 1;
            w = $urandom_range(k > 2 ? k - 1 : 1, k + 8);
            h = $urandom_range(k > 2 ? k - 1 : 1, k + 5);
            set_geometry(k, w, h);
            repeat ($urandom_range(1, 2))
            begin
                send_frame(w, h, $urandom_range(0, 3) == 0 ? 2 : 0);
                sent += w * h;
            end
        end
    endtask

    task automatic test_backpressure();
        sender_idle_pct = 0;
        stall_pct = 0;
        set_geometry(3, 8, 6);
        hold_left = 4000;
        send_frame(8, 6, 0);
        send_frame(8, 6, 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_KERNEL_SIZE;
        cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        hold_left = 0;
        sender_idle_pct = 0;
        stall_pct = 0;
        kernel_reg = RESET_KERNEL;
        width_reg = RESET_WIDTH;
        height_reg = RESET_HEIGHT;
        col_pos = 0;
        row_pos = 0;
        foreach (line_rows[i])
            line_rows[i] = '0;
        foreach (window_px[c, j])
            window_px[c][j] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_windows();
        test_register_extremes();
        test_random_frames(0, 0, 100);
        test_random_frames(68, 0, 100);
        test_random_frames(0, 68, 100);
        test_random_frames(28, 28, 100);
        test_backpressure();

        wait_drained();
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
